// File: src/wps_pkg.sv
// Package for the WAV PCM16 stream parser: word types, status codes, header tags.
// Used by every module of the parser; depends on nothing.
package wps_pkg;

  localparam logic       KIND_SAMPLE = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;

  localparam logic [31:0] RIFF_TAG = 32'h4646_4952;
  localparam logic [31:0] WAVE_TAG = 32'h4556_4157;
  localparam logic [31:0] DATA_TAG = 32'h6174_6164;

  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SHORT     = 3'd1,
    ST_NO_RIFF   = 3'd2,
    ST_NO_WAVE   = 3'd3,
    ST_NO_DATA   = 3'd4,
    ST_BAD_LEN   = 3'd5,
    ST_TRUNCATED = 3'd6
  } wps_status_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       end_of_file;
  } wps_in_t;

  typedef struct packed {
    logic               kind;
    logic signed [15:0] sample;
    wps_status_t        status;
    logic [15:0]        channel_count;
    logic [31:0]        rate_hz;
    logic               final_res;
  } wps_res_t;

  typedef struct packed {
    logic [1:0] count;
    wps_res_t   first;
    wps_res_t   second;
  } wps_push_t;

endpackage

// File: src/wps_parser.sv
// Header capture, chunk walk and sample pairing for one accepted byte.
// Holds the parse state registers; emits up to two result words. Uses wps_pkg.
module wps_parser import wps_pkg::*; #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  wps_in_t   word,
  output wps_push_t push
);

  localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;
  localparam logic [POSITION_WIDTH-1:0] P4  = POSITION_WIDTH'(4);
  localparam logic [POSITION_WIDTH-1:0] P8  = POSITION_WIDTH'(8);
  localparam logic [POSITION_WIDTH-1:0] P12 = POSITION_WIDTH'(12);
  localparam logic [POSITION_WIDTH-1:0] P22 = POSITION_WIDTH'(22);
  localparam logic [POSITION_WIDTH-1:0] P23 = POSITION_WIDTH'(23);
  localparam logic [POSITION_WIDTH-1:0] P24 = POSITION_WIDTH'(24);
  localparam logic [POSITION_WIDTH-1:0] P28 = POSITION_WIDTH'(28);
  localparam logic [POSITION_WIDTH-1:0] P43 = POSITION_WIDTH'(43);

  logic [POSITION_WIDTH-1:0] pos_r, pos_nxt;
  logic        riff_bad_r, riff_bad_nxt;
  logic        wave_bad_r, wave_bad_nxt;
  logic [15:0] channels_r, channels_nxt;
  logic [31:0] rate_r, rate_nxt;
  logic [55:0] hdr_shift_r, hdr_shift_nxt;
  logic [2:0]  hdr_fill_r, hdr_fill_nxt;
  logic [32:0] skip_r, skip_nxt;
  logic        data_found_r, data_found_nxt;
  logic        len_bad_r, len_bad_nxt;
  logic [31:0] data_rem_r, data_rem_nxt;
  logic [7:0]  low_hold_r, low_hold_nxt;
  logic        phase_r, phase_nxt;

  logic [63:0] shift_full;
  logic [31:0] chunk_id;
  logic [31:0] chunk_size;
  logic        sample_out;
  wps_res_t    sample_res;
  wps_res_t    status_res;
  wps_status_t status_code;

  assign shift_full = {word.byte_value, hdr_shift_r};
  assign chunk_id   = shift_full[31:0];
  assign chunk_size = shift_full[63:32];

  always_comb begin
    pos_nxt        = pos_r;
    riff_bad_nxt   = riff_bad_r;
    wave_bad_nxt   = wave_bad_r;
    channels_nxt   = channels_r;
    rate_nxt       = rate_r;
    hdr_shift_nxt  = hdr_shift_r;
    hdr_fill_nxt   = hdr_fill_r;
    skip_nxt       = skip_r;
    data_found_nxt = data_found_r;
    len_bad_nxt    = len_bad_r;
    data_rem_nxt   = data_rem_r;
    low_hold_nxt   = low_hold_r;
    phase_nxt      = phase_r;
    sample_out     = 1'b0;
    status_code    = ST_OK;

    if (pos_r < P4) begin
      if (word.byte_value != RIFF_TAG[{pos_r[1:0], 3'b000} +: 8]) begin
        riff_bad_nxt = 1'b1;
      end
    end else if (pos_r >= P8 && pos_r < P12) begin
      if (word.byte_value != WAVE_TAG[{pos_r[1:0], 3'b000} +: 8]) begin
        wave_bad_nxt = 1'b1;
      end
    end else if (pos_r == P22) begin
      channels_nxt[7:0] = word.byte_value;
    end else if (pos_r == P23) begin
      channels_nxt[15:8] = word.byte_value;
    end else if (pos_r >= P24 && pos_r < P28) begin
      rate_nxt[{pos_r[1:0], 3'b000} +: 8] = word.byte_value;
    end

    if (data_found_r) begin
      if (data_rem_r != 32'd0) begin
        data_rem_nxt = data_rem_r - 32'd1;
        if (!phase_r) begin
          low_hold_nxt = word.byte_value;
          phase_nxt    = 1'b1;
        end else begin
          phase_nxt  = 1'b0;
          sample_out = 1'b1;
        end
      end
    end else if (pos_r >= P12) begin
      if (skip_r != 33'd0) begin
        skip_nxt = skip_r - 33'd1;
      end else begin
        hdr_shift_nxt = shift_full[63:8];
        if (hdr_fill_r == 3'd7) begin
          hdr_fill_nxt = 3'd0;
          if (chunk_id == DATA_TAG) begin
            data_found_nxt = 1'b1;
            if (chunk_size == 32'd0 || chunk_size[31]) begin
              len_bad_nxt  = 1'b1;
              data_rem_nxt = 32'd0;
            end else begin
              data_rem_nxt = chunk_size;
            end
          end else begin
            skip_nxt = {1'b0, chunk_size} + {32'd0, chunk_size[0]};
          end
        end else begin
          hdr_fill_nxt = hdr_fill_r + 3'd1;
        end
      end
    end

    if (pos_r != POS_MAX) begin
      pos_nxt = pos_r + 1'b1;
    end

    if (pos_r < P43) begin
      status_code = ST_SHORT;
    end else if (riff_bad_nxt) begin
      status_code = ST_NO_RIFF;
    end else if (wave_bad_nxt) begin
      status_code = ST_NO_WAVE;
    end else if (!data_found_nxt) begin
      status_code = ST_NO_DATA;
    end else if (len_bad_nxt) begin
      status_code = ST_BAD_LEN;
    end else if (data_rem_nxt != 32'd0) begin
      status_code = ST_TRUNCATED;
    end

    sample_res.kind          = KIND_SAMPLE;
    sample_res.sample        = {word.byte_value, low_hold_r};
    sample_res.status        = ST_OK;
    sample_res.channel_count = 16'd0;
    sample_res.rate_hz       = 32'd0;
    sample_res.final_res     = !word.end_of_file;

    status_res.kind          = KIND_STATUS;
    status_res.sample        = 16'sd0;
    status_res.status        = status_code;
    status_res.channel_count = channels_nxt;
    status_res.rate_hz       = rate_nxt;
    status_res.final_res     = 1'b1;

    // start a new file after the final byte
    if (word.end_of_file) begin
      pos_nxt        = '0;
      riff_bad_nxt   = 1'b0;
      wave_bad_nxt   = 1'b0;
      channels_nxt   = 16'd0;
      rate_nxt       = 32'd0;
      hdr_shift_nxt  = 56'd0;
      hdr_fill_nxt   = 3'd0;
      skip_nxt       = 33'd0;
      data_found_nxt = 1'b0;
      len_bad_nxt    = 1'b0;
      data_rem_nxt   = 32'd0;
      low_hold_nxt   = 8'd0;
      phase_nxt      = 1'b0;
    end
  end

  always_comb begin
    push.count  = 2'd0;
    push.first  = sample_out ? sample_res : status_res;
    push.second = status_res;
    if (accept) begin
      push.count = 2'({1'b0, sample_out} + {1'b0, word.end_of_file});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      riff_bad_r   <= 1'b0;
      wave_bad_r   <= 1'b0;
      channels_r   <= 16'd0;
      rate_r       <= 32'd0;
      hdr_shift_r  <= 56'd0;
      hdr_fill_r   <= 3'd0;
      skip_r       <= 33'd0;
      data_found_r <= 1'b0;
      len_bad_r    <= 1'b0;
      data_rem_r   <= 32'd0;
      low_hold_r   <= 8'd0;
      phase_r      <= 1'b0;
    end else if (accept) begin
      pos_r        <= pos_nxt;
      riff_bad_r   <= riff_bad_nxt;
      wave_bad_r   <= wave_bad_nxt;
      channels_r   <= channels_nxt;
      rate_r       <= rate_nxt;
      hdr_shift_r  <= hdr_shift_nxt;
      hdr_fill_r   <= hdr_fill_nxt;
      skip_r       <= skip_nxt;
      data_found_r <= data_found_nxt;
      len_bad_r    <= len_bad_nxt;
      data_rem_r   <= data_rem_nxt;
      low_hold_r   <= low_hold_nxt;
      phase_r      <= phase_nxt;
    end
  end

endmodule

// File: src/wps_result_fifo.sv
// Result queue: takes up to two result words a cycle, hands out one a cycle while out_stall is low.
// Uses wps_pkg for the result word and push types.
module wps_result_fifo import wps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  wps_push_t push,
  output logic      room_for_two,
  output logic      out_valid,
  input  logic      out_stall,
  output wps_res_t  out_word
);

  wps_res_t mem_r [FIFO_DEPTH];

  logic [FIFO_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]   count_r, count_nxt;
  logic               pop;
  logic [FIFO_AW-1:0] wr_ptr_inc;

  assign pop          = out_valid && !out_stall;
  assign out_valid    = count_r != '0;
  assign out_word     = mem_r[rd_ptr_r];
  assign room_for_two = count_r <= (FIFO_AW + 1)'(FIFO_DEPTH - 2);
  assign wr_ptr_inc   = wr_ptr_r + 1'b1;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + FIFO_AW'(push.count);
    rd_ptr_nxt = rd_ptr_r + FIFO_AW'(pop);
    count_nxt  = count_r + (FIFO_AW + 1)'(push.count) - (FIFO_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wr_ptr_inc] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// File: src/wav_pcm16_stream_parser.sv
// Top level of the WAV PCM16 stream parser: parse stage feeding a result queue.
// Depends on wps_pkg, wps_parser and wps_result_fifo.
//
//   channel | ports                       | word
//   input   | in_valid, in_stall, in_word | wps_in_t  (byte_value, end_of_file)
//   result  | out_valid, out_stall, out_word | wps_res_t (samples, then status)
//
// One byte is taken per cycle while in_stall is low; its results land in the queue at the next edge.
// When the queue is empty, a result reaches the queue head in the cycle after its byte is taken.
// The queue holds four words; in_stall rises while fewer than two slots are free,
// so a byte that yields a sample and a status never overflows it.
// Synchronous active-low reset clears the parse state and empties the queue.
module wav_pcm16_stream_parser import wps_pkg::*; #(
  parameter int POSITION_WIDTH = 32
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  wps_in_t  in_word,
  output logic     out_valid,
  input  logic     out_stall,
  output wps_res_t out_word
);

  wps_push_t push;
  logic      room_for_two;
  logic      accept;

  assign in_stall = !room_for_two;
  assign accept   = in_valid && room_for_two;

  wps_parser #(
    .POSITION_WIDTH(POSITION_WIDTH)
  ) u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .accept(accept),
    .word  (in_word),
    .push  (push)
  );

  wps_result_fifo u_fifo (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .room_for_two(room_for_two),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_word    (out_word)
  );

endmodule
